// ===== rtl/core/tgq_pkg.sv =====
// shared types and constants of the triangle geometry query block
package tgq_pkg;

	localparam int InDataW  = 152;
	localparam int InUserW  = 2;
	localparam int OutDataW = 192;
	localparam int OutUserW = 1;

	localparam int SqrtSteps = 66;
	localparam int DivSteps  = 17;

	// ceil(2^34 / 3): exact floor division by three for dividends below 2^33
	localparam logic [32:0] CenRecip = 33'd5726623062;

	typedef enum logic [1:0] {
		FUNC_WR_VERTEX   = 2'd0,
		FUNC_WR_TRIANGLE = 2'd1,
		FUNC_QUERY       = 2'd2
	} func_t;

	typedef enum logic [18:0] {
		ST_IDLE  = 19'h00001,
		ST_TWT   = 19'h00002,
		ST_VRD   = 19'h00004,
		ST_VWT   = 19'h00008,
		ST_EDGE  = 19'h00010,
		ST_CEN   = 19'h00020,
		ST_XMUL  = 19'h00040,
		ST_XACC  = 19'h00080,
		ST_MAG   = 19'h00100,
		ST_SQMUL = 19'h00200,
		ST_SQACC = 19'h00400,
		ST_RTLD  = 19'h00800,
		ST_SQRT  = 19'h01000,
		ST_RTDN  = 19'h02000,
		ST_NORM  = 19'h04000,
		ST_SSMUL = 19'h08000,
		ST_SSACC = 19'h10000,
		ST_DIV   = 19'h20000,
		ST_FIN   = 19'h40000
	} state_t;

endpackage

// ===== rtl/core/triangle_geometry_query.sv =====
// triangle geometry query: vertex and triangle stores with normal, centroid and area unit
//
// input channel s_*: one beat per item, tuser carries the function code
//   write vertex   - stores pos_x/y/z at vertex_slot (ignored beyond the store depth)
//   write triangle - stores corner_a/b/c at triangle_slot (ignored beyond the store depth)
//   query          - reads the triangle at triangle_slot and its three vertices
// output channel m_*: exactly one beat per input beat; writes give an all-zero beat
// a query beat carries unit normal (Q1.15), centroid (Q16.16), area (Q32.16, saturating)
// and the degenerate flag in tuser
// one item at a time; a query runs two 66-step square roots on a 132-bit
// remainder, a centroid divide by reciprocal multiplication, a
// one-bit-per-cycle normalizing shift of up to 34 steps and a 17-step normal
// divide; a degenerate query goes from the cross product straight to the result
// a beat is accepted only in idle; the result sits in an output register, and a
// stalled receiver holds the block in its final state until the previous beat is taken
// reset clears the control state only; store contents are undefined until written
// and no clearing pass runs, so the block is ready in the first cycle after reset
module triangle_geometry_query
	import tgq_pkg::*;
#(
	parameter int VERTEX_DEPTH   = 1024,
	parameter int TRIANGLE_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// vertex_slot, triangle_slot, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c, zero pad
	input  logic [InDataW-1:0]  s_tdata,
	// func
	input  logic [InUserW-1:0]  s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// normal_x, normal_y, normal_z, centroid_x, centroid_y, centroid_z, area
	output logic [OutDataW-1:0] m_tdata,
	// degenerate
	output logic [OutUserW-1:0] m_tuser
);

	localparam int VA = $clog2(VERTEX_DEPTH);
	localparam int TA = (TRIANGLE_DEPTH > 1) ? $clog2(TRIANGLE_DEPTH) : 1;

	// storage
	logic [95:0] vmem [VERTEX_DEPTH];
	logic [29:0] tmem [TRIANGLE_DEPTH];
	logic [95:0] vrd_q;
	logic [29:0] trd_q;

	// control
	state_t     state_q;
	logic [1:0] vi_q, ci_q, pi_q;
	logic [2:0] k_q;
	logic [6:0] cnt_q;
	logic       pass_q, query_q, m_tvalid_q;

	// datapath
	logic        tri_ok_q, vok_q, degen_q;
	logic [9:0]  corner_q [3];
	logic [95:0] p_q [3];
	logic signed [32:0] e1_q [3];
	logic signed [32:0] e2_q [3];
	logic        cneg_q [3];
	logic [32:0] cd_q [3];
	logic signed [66:0] c_q [3];
	logic [64:0] mag_q [3];
	logic        neg_q [3];
	logic [131:0] acc_q;
	logic signed [67:0] prod_q;
	logic [131:0] sq_n_q, sq_res_q, sq_bit_q;
	logic [64:0] v_q [3];
	logic [32:0] len_q;
	logic [32:0] dr_q [3];
	logic [16:0] dq_q [3];
	logic [47:0] area_q;
	logic [OutDataW-1:0] m_tdata_q;
	logic [OutUserW-1:0] m_tuser_q;

	// input fields
	func_t       in_func;
	logic [9:0]  in_vslot, in_tslot;
	logic [16:0] vslot_ext, tslot_ext, corner_ext;
	logic        vslot_ok, tslot_ok, corner_ok;
	logic        accept, vwe, twe, out_free;
	logic [VA-1:0] vwaddr, vraddr;
	logic [TA-1:0] taddr;

	assign in_func   = func_t'(s_tuser);
	assign in_vslot  = s_tdata[9:0];
	assign in_tslot  = s_tdata[19:10];
	assign vslot_ext = {7'd0, in_vslot};
	assign tslot_ext = {7'd0, in_tslot};
	assign vslot_ok  = vslot_ext < 17'(VERTEX_DEPTH);
	assign tslot_ok  = tslot_ext < 17'(TRIANGLE_DEPTH);
	assign vwaddr    = vslot_ext[VA-1:0];
	assign taddr     = tslot_ext[TA-1:0];
	assign corner_ext = {7'd0, corner_q[vi_q]};
	assign corner_ok  = corner_ext < 17'(VERTEX_DEPTH);
	assign vraddr     = corner_ext[VA-1:0];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign vwe      = accept && (in_func == FUNC_WR_VERTEX) && vslot_ok;
	assign twe      = accept && (in_func == FUNC_WR_TRIANGLE) && tslot_ok;
	assign out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// vertex store, one write and one read port, registered read
	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[vwaddr] <= s_tdata[115:20];
		end
		vrd_q <= vmem[vraddr];
	end

	// triangle store, single address shared by write and read
	always_ff @(posedge clk) begin
		if (twe) begin
			tmem[taddr] <= s_tdata[145:116];
		end
		trd_q <= tmem[taddr];
	end

	// shared multiplier operand selection
	logic signed [33:0] mul_a, mul_b;
	logic [64:0] sq_m;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		sq_m  = mag_q[ci_q];
		unique case (state_q)
			ST_CEN: begin
				// divide by three as a multiply by the rounded-up reciprocal
				case (k_q)
					3'd0: mul_a = {1'b0, cd_q[0]};
					3'd1: mul_a = {1'b0, cd_q[1]};
					3'd2: mul_a = {1'b0, cd_q[2]};
					default: mul_a = '0;
				endcase
				mul_b = {1'b0, CenRecip};
			end
			ST_XMUL: begin
				case (k_q)
					3'd0: begin mul_a = {e1_q[1][32], e1_q[1]}; mul_b = {e2_q[2][32], e2_q[2]}; end
					3'd1: begin mul_a = {e1_q[2][32], e1_q[2]}; mul_b = {e2_q[1][32], e2_q[1]}; end
					3'd2: begin mul_a = {e1_q[2][32], e1_q[2]}; mul_b = {e2_q[0][32], e2_q[0]}; end
					3'd3: begin mul_a = {e1_q[0][32], e1_q[0]}; mul_b = {e2_q[2][32], e2_q[2]}; end
					3'd4: begin mul_a = {e1_q[0][32], e1_q[0]}; mul_b = {e2_q[1][32], e2_q[1]}; end
					default: begin
						mul_a = {e1_q[1][32], e1_q[1]};
						mul_b = {e2_q[0][32], e2_q[0]};
					end
				endcase
			end
			ST_SQMUL: begin
				// magnitude split as high 32 bits over low 33 bits
				case (pi_q)
					2'd0: begin mul_a = {1'b0, sq_m[32:0]}; mul_b = {1'b0, sq_m[32:0]}; end
					2'd1: begin mul_a = {2'b0, sq_m[64:33]}; mul_b = {1'b0, sq_m[32:0]}; end
					default: begin
						mul_a = {2'b0, sq_m[64:33]};
						mul_b = {2'b0, sq_m[64:33]};
					end
				endcase
			end
			ST_SSMUL: begin
				mul_a = {3'b0, v_q[ci_q][30:0]};
				mul_b = {3'b0, v_q[ci_q][30:0]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// square root step: restoring, two remainder bits per step
	logic [131:0] sq_t;
	logic         sq_ge;
	assign sq_t  = sq_res_q + sq_bit_q;
	assign sq_ge = sq_n_q >= sq_t;

	// normalizing shift: bring the largest magnitude to exactly 31 bits
	logic [64:0] norm_or;
	logic        norm_hi, norm_done;
	assign norm_or   = v_q[0] | v_q[1] | v_q[2];
	assign norm_hi   = |norm_or[64:31];
	assign norm_done = !norm_hi && norm_or[30];

	logic cross_zero;
	assign cross_zero = (c_q[0] == '0) && (c_q[1] == '0) && (c_q[2] == '0);

	// area from the first root, rounded and saturated
	logic [66:0] area_sum;
	logic [49:0] area_full;
	assign area_sum  = {1'b0, sq_res_q[65:0]} + 67'h10000;
	assign area_full = area_sum[66:17];

	// normal divide setup from the second root
	logic [46:0] num [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i] = {1'b0, v_q[i][30:0], 15'd0} + 47'(sq_res_q[32:1]);
		end
	end

	// result assembly
	logic [15:0] nrm [3];
	logic [31:0] cent [3];
	logic [OutDataW-1:0] res_data;
	logic [14:0] nmag [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nmag[i] = (dq_q[i] > 17'd32767) ? 15'h7fff : dq_q[i][14:0];
			nrm[i]  = neg_q[i] ? (16'd0 - {1'b0, nmag[i]}) : {1'b0, nmag[i]};
			if (degen_q) begin
				nrm[i] = '0;
			end
			cent[i] = cneg_q[i] ? (32'd0 - cd_q[i][31:0]) : cd_q[i][31:0];
		end
		res_data = {(degen_q ? 48'd0 : area_q), cent[2], cent[1], cent[0],
			nrm[2], nrm[1], nrm[0]};
		if (!query_q) begin
			res_data = '0;
		end
	end

	// output valid: set when the result register loads, cleared when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vi_q       <= '0;
			ci_q       <= '0;
			pi_q       <= '0;
			k_q        <= '0;
			cnt_q      <= '0;
			pass_q     <= 1'b0;
			query_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						query_q <= (in_func == FUNC_QUERY);
						state_q <= (in_func == FUNC_QUERY) ? ST_TWT : ST_FIN;
					end
				end
				ST_TWT: begin
					vi_q    <= '0;
					state_q <= ST_VRD;
				end
				ST_VRD: state_q <= ST_VWT;
				ST_VWT: begin
					if (vi_q == 2'd2) begin
						state_q <= ST_EDGE;
					end else begin
						vi_q    <= vi_q + 2'd1;
						state_q <= ST_VRD;
					end
				end
				ST_EDGE: begin
					k_q     <= '0;
					state_q <= ST_CEN;
				end
				ST_CEN: begin
					// three products issued at k_q 0 to 2, each captured from the product register at k_q 1 to 3
					if (k_q == 3'd3) begin
						k_q     <= '0;
						state_q <= ST_XMUL;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				ST_XMUL: state_q <= ST_XACC;
				ST_XACC: begin
					if (k_q == 3'd5) begin
						state_q <= ST_MAG;
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= ST_XMUL;
					end
				end
				ST_MAG: begin
					ci_q    <= '0;
					pi_q    <= '0;
					state_q <= cross_zero ? ST_FIN : ST_SQMUL;
				end
				ST_SQMUL: state_q <= ST_SQACC;
				ST_SQACC: begin
					if (pi_q == 2'd2) begin
						pi_q <= '0;
						if (ci_q == 2'd2) begin
							pass_q  <= 1'b0;
							state_q <= ST_RTLD;
						end else begin
							ci_q    <= ci_q + 2'd1;
							state_q <= ST_SQMUL;
						end
					end else begin
						pi_q    <= pi_q + 2'd1;
						state_q <= ST_SQMUL;
					end
				end
				ST_RTLD: begin
					cnt_q   <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (cnt_q == 7'(SqrtSteps - 1)) begin
						state_q <= ST_RTDN;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_RTDN: begin
					cnt_q   <= '0;
					state_q <= pass_q ? ST_DIV : ST_NORM;
				end
				ST_NORM: begin
					if (norm_done) begin
						ci_q    <= '0;
						state_q <= ST_SSMUL;
					end
				end
				ST_SSMUL: state_q <= ST_SSACC;
				ST_SSACC: begin
					if (ci_q == 2'd2) begin
						pass_q  <= 1'b1;
						state_q <= ST_RTLD;
					end else begin
						ci_q    <= ci_q + 2'd1;
						state_q <= ST_SSMUL;
					end
				end
				ST_DIV: begin
					if (cnt_q == 7'(DivSteps - 1)) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					tri_ok_q <= tslot_ok;
					degen_q  <= 1'b0;
				end
			end
			ST_TWT: begin
				// a slot beyond the store reads as corners zero
				corner_q[0] <= tri_ok_q ? trd_q[9:0] : 10'd0;
				corner_q[1] <= tri_ok_q ? trd_q[19:10] : 10'd0;
				corner_q[2] <= tri_ok_q ? trd_q[29:20] : 10'd0;
			end
			ST_VRD: vok_q <= corner_ok;
			ST_VWT: p_q[vi_q] <= vok_q ? vrd_q : 96'd0;
			ST_EDGE: begin
				for (int j = 0; j < 3; j++) begin
					logic [33:0] s;
					logic [33:0] sa;
					s = {{2{p_q[0][32*j+31]}}, p_q[0][32*j +: 32]}
						+ {{2{p_q[1][32*j+31]}}, p_q[1][32*j +: 32]}
						+ {{2{p_q[2][32*j+31]}}, p_q[2][32*j +: 32]};
					sa = s[33] ? (34'd0 - s) : s;
					cneg_q[j] <= s[33];
					cd_q[j]   <= sa[32:0] + 33'd1;
					e1_q[j] <= {p_q[1][32*j+31], p_q[1][32*j +: 32]}
						- {p_q[0][32*j+31], p_q[0][32*j +: 32]};
					e2_q[j] <= {p_q[2][32*j+31], p_q[2][32*j +: 32]}
						- {p_q[0][32*j+31], p_q[0][32*j +: 32]};
				end
			end
			ST_CEN: begin
				// quotient is the product shifted down by 34
				prod_q <= mul_a * mul_b;
				case (k_q)
					3'd1: cd_q[0] <= prod_q[66:34];
					3'd2: cd_q[1] <= prod_q[66:34];
					3'd3: cd_q[2] <= prod_q[66:34];
					default: begin
					end
				endcase
			end
			ST_XMUL, ST_SQMUL, ST_SSMUL: prod_q <= mul_a * mul_b;
			ST_XACC: begin
				if (!k_q[0]) begin
					c_q[k_q[2:1]] <= prod_q[66:0];
				end else begin
					c_q[k_q[2:1]] <= c_q[k_q[2:1]] - prod_q[66:0];
				end
			end
			ST_MAG: begin
				for (int i = 0; i < 3; i++) begin
					logic signed [66:0] na;
					na = -c_q[i];
					neg_q[i] <= c_q[i][66];
					mag_q[i] <= c_q[i][66] ? na[64:0] : c_q[i][64:0];
				end
				acc_q <= '0;
				if (cross_zero) begin
					degen_q <= 1'b1;
				end
			end
			ST_SQACC: begin
				case (pi_q)
					2'd0: acc_q <= acc_q + {66'd0, prod_q[65:0]};
					2'd1: acc_q <= acc_q + {32'd0, prod_q[65:0], 34'd0};
					default: acc_q <= acc_q + {prod_q[65:0], 66'd0};
				endcase
			end
			ST_RTLD: begin
				sq_n_q   <= acc_q;
				sq_res_q <= '0;
				sq_bit_q <= {2'b01, 130'd0};
			end
			ST_SQRT: begin
				sq_n_q   <= sq_ge ? (sq_n_q - sq_t) : sq_n_q;
				sq_res_q <= (sq_res_q >> 1) + (sq_ge ? sq_bit_q : 132'd0);
				sq_bit_q <= sq_bit_q >> 2;
			end
			ST_RTDN: begin
				if (!pass_q) begin
					area_q <= (|area_full[49:48]) ? {48{1'b1}} : area_full[47:0];
					for (int i = 0; i < 3; i++) begin
						v_q[i] <= mag_q[i];
					end
					acc_q <= '0;
				end else begin
					len_q <= sq_res_q[32:0];
					for (int i = 0; i < 3; i++) begin
						dr_q[i] <= {3'd0, num[i][46:17]};
						dq_q[i] <= num[i][16:0];
					end
				end
			end
			ST_NORM: begin
				for (int i = 0; i < 3; i++) begin
					if (norm_hi) begin
						v_q[i] <= v_q[i] >> 1;
					end else if (!norm_or[30]) begin
						v_q[i] <= v_q[i] << 1;
					end
				end
			end
			ST_SSACC: acc_q <= acc_q + {66'd0, prod_q[65:0]};
			ST_DIV: begin
				for (int i = 0; i < 3; i++) begin
					logic [33:0] t;
					logic [33:0] d;
					logic        ge;
					t  = {dr_q[i], dq_q[i][16]};
					ge = t >= {1'b0, len_q};
					d  = t - {1'b0, len_q};
					dr_q[i] <= ge ? d[32:0] : t[32:0];
					dq_q[i] <= {dq_q[i][15:0], ge};
				end
			end
			ST_FIN: begin
				if (out_free) begin
					m_tdata_q <= res_data;
					m_tuser_q <= query_q ? degen_q : 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
